### design/mrit_pkg.sv
// Shared types, codes and sizes for the merged row index table.
package mrit_pkg;

    // Default sizes for the top-level parameters
    localparam int MAX_LISTS_DEF  = 8;
    localparam int MAX_ROWS_DEF   = 4096;
    localparam int INDEX_BITS_DEF = 24;

    // Fixed port field widths
    localparam int OPCODE_W = 1;
    localparam int VALUE_W  = 24;
    localparam int ROWIDX_W = 12;
    localparam int NTH_W    = 3;
    localparam int STATUS_W = 2;
    localparam int ROWCNT_W = 13;
    localparam int COUNT_W  = 4;
    localparam int MASK_W   = 8;
    localparam int SLOT_W   = 3;
    localparam int LC_W     = 4;

    localparam logic [LC_W-1:0] LIST_COUNT_RESET = 4'd1;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_APPEND = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_ROW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // Control from the sequencer to the row scanner
    typedef struct packed {
        logic              clear;
        logic              beat;
        logic [SLOT_W-1:0] slot;
        logic [NTH_W-1:0]  nth;
    } t_scan_ctl;

    // Summary of the scanned row
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [MASK_W-1:0]  mask;
        logic               found;
        logic [SLOT_W-1:0]  slot;
    } t_scan_res;

endpackage

### design/merged_row_index_table.sv
// Top level: append-only row table with per-row rank query.
//
// Channel  | Direction | Handshake                    | Beat
// ---------+-----------+------------------------------+----------------------------------
// input    | in        | i_valid / o_ready            | opcode, entry, row_index, nth
// result   | out       | o_valid / i_ready            | status, row_count, query fields
// config   | in        | i_cfg_valid / o_cfg_ready    | list_count
//
// An append is accepted in ST_IDLE and then loads the result register in ST_EMIT.
// A query steps through ST_SCAN, with one memory read per slot on the single read port,
// then ST_DRAIN for the last read data, and ST_EMIT to load the result.
// Wrong-row queries and a list_count of zero go from ST_IDLE straight to ST_EMIT.
// Reset is synchronous and active low; the entry memory is not cleared.
// A new item is accepted while a previous result waits in the output register;
// a stalled output holds the sequencer in its last state.
module merged_row_index_table #(
    parameter int MAX_LISTS  = mrit_pkg::MAX_LISTS_DEF,
    parameter int MAX_ROWS   = mrit_pkg::MAX_ROWS_DEF,
    parameter int INDEX_BITS = mrit_pkg::INDEX_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [mrit_pkg::OPCODE_W-1:0]    i_opcode,
    input  logic                             i_entry_valid,
    input  logic [mrit_pkg::VALUE_W-1:0]     i_entry_value,
    input  logic [mrit_pkg::ROWIDX_W-1:0]    i_row_index,
    input  logic [mrit_pkg::NTH_W-1:0]       i_nth,
    // result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [mrit_pkg::STATUS_W-1:0]    o_status,
    output logic [mrit_pkg::ROWCNT_W-1:0]    o_row_count,
    output logic [mrit_pkg::COUNT_W-1:0]     o_valid_count,
    output logic [mrit_pkg::MASK_W-1:0]      o_valid_mask,
    output logic                             o_found,
    output logic [mrit_pkg::SLOT_W-1:0]      o_list_slot,
    output logic [mrit_pkg::VALUE_W-1:0]     o_single_index,
    // configuration channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mrit_pkg::LC_W-1:0]        i_cfg_list_count
);

    localparam int SLOT_BITS = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int CNT_W     = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W    = ROW_W + SLOT_BITS;
    localparam int DATA_W    = INDEX_BITS + 1;
    localparam int CMP_W     = (CNT_W > mrit_pkg::ROWIDX_W) ? CNT_W : mrit_pkg::ROWIDX_W;
    localparam int LC_W      = mrit_pkg::LC_W;

    mrit_pkg::t_state                r_state;
    mrit_pkg::t_state                n_state;
    logic [LC_W-1:0]                 r_list_count;
    logic [SLOT_BITS-1:0]            r_fill;
    logic [SLOT_BITS-1:0]            n_fill;
    logic [CNT_W-1:0]                r_committed;
    logic [CNT_W-1:0]                n_committed;
    logic [ROW_W-1:0]                r_row;
    logic [ROW_W-1:0]                n_row;
    logic [mrit_pkg::NTH_W-1:0]      r_nth;
    logic [mrit_pkg::NTH_W-1:0]      n_nth;
    logic [LC_W-1:0]                 r_rd_slot;
    logic [LC_W-1:0]                 n_rd_slot;
    logic                            r_beat;
    logic                            n_beat;
    logic [mrit_pkg::SLOT_W-1:0]     r_beat_slot;
    logic [mrit_pkg::SLOT_W-1:0]     n_beat_slot;
    logic [mrit_pkg::STATUS_W-1:0]   r_pend_status;
    logic [mrit_pkg::STATUS_W-1:0]   n_pend_status;
    logic                            r_pend_scan;
    logic                            n_pend_scan;
    logic                            r_out_valid;
    logic                            n_out_valid;
    logic [mrit_pkg::STATUS_W-1:0]   r_out_status;
    logic [mrit_pkg::ROWCNT_W-1:0]   r_out_row_count;
    logic [mrit_pkg::COUNT_W-1:0]    r_out_count;
    logic [mrit_pkg::MASK_W-1:0]     r_out_mask;
    logic                            r_out_found;
    logic [mrit_pkg::SLOT_W-1:0]     r_out_slot;
    logic [mrit_pkg::VALUE_W-1:0]    r_out_index;

    logic                            in_beat;
    logic                            out_load;
    logic [LC_W-1:0]                 lc_act;
    logic                            table_full;
    logic                            row_bad;
    logic [LC_W-1:0]                 fill_next;
    logic                            wr_en;
    logic [ADDR_W-1:0]               wr_addr;
    logic [DATA_W-1:0]               wr_data;
    logic                            rd_en;
    logic [ADDR_W-1:0]               rd_addr;
    logic [DATA_W-1:0]               rd_data;
    mrit_pkg::t_scan_ctl             scan_ctl;
    mrit_pkg::t_scan_res             scan_res;
    logic [INDEX_BITS-1:0]           scan_index;

    // Clamp list count to the row width
    assign lc_act = (r_list_count > LC_W'(MAX_LISTS)) ? LC_W'(MAX_LISTS) : r_list_count;

    assign table_full = (r_committed == CNT_W'(MAX_ROWS));
    assign row_bad    = (CMP_W'(i_row_index) >= CMP_W'(r_committed));
    assign fill_next  = LC_W'(r_fill) + LC_W'(1);

    assign o_ready     = (r_state == mrit_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_beat     = i_valid && o_ready;

    // Sequencer: next state, memory access and scanner control
    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_committed   = r_committed;
        n_row         = r_row;
        n_nth         = r_nth;
        n_rd_slot     = r_rd_slot;
        n_beat        = 1'b0;
        n_beat_slot   = r_beat_slot;
        n_pend_status = r_pend_status;
        n_pend_scan   = r_pend_scan;
        wr_en         = 1'b0;
        wr_addr       = {ROW_W'(r_committed), r_fill};
        wr_data       = i_entry_valid ? {1'b1, INDEX_BITS'(i_entry_value)} : '0;
        rd_en         = 1'b0;
        rd_addr       = {r_row, r_rd_slot[SLOT_BITS-1:0]};
        out_load      = 1'b0;
        scan_ctl      = '{clear: 1'b0, beat: r_beat, slot: r_beat_slot, nth: r_nth};
        case (r_state)
            mrit_pkg::ST_IDLE: begin
                if (in_beat) begin
                    n_pend_status = mrit_pkg::STAT_OK;
                    n_pend_scan   = 1'b0;
                    n_state       = mrit_pkg::ST_EMIT;
                    if (i_opcode == mrit_pkg::OP_APPEND) begin
                        if (lc_act != '0) begin
                            if (table_full) begin
                                n_pend_status = mrit_pkg::STAT_FULL;
                            end else begin
                                wr_en = 1'b1;
                                if (fill_next >= lc_act) begin
                                    n_fill      = '0;
                                    n_committed = r_committed + CNT_W'(1);
                                end else begin
                                    n_fill = SLOT_BITS'(fill_next);
                                end
                            end
                        end
                    end else if (row_bad) begin
                        n_pend_status = mrit_pkg::STAT_BAD_ROW;
                    end else if (lc_act != '0) begin
                        n_pend_scan    = 1'b1;
                        n_row          = ROW_W'(i_row_index);
                        n_nth          = i_nth;
                        n_rd_slot      = '0;
                        scan_ctl.clear = 1'b1;
                        n_state        = mrit_pkg::ST_SCAN;
                    end
                end
            end
            mrit_pkg::ST_SCAN: begin
                // Issue one slot read per cycle
                rd_en       = 1'b1;
                n_beat      = 1'b1;
                n_beat_slot = mrit_pkg::SLOT_W'(r_rd_slot);
                n_rd_slot   = r_rd_slot + LC_W'(1);
                if (n_rd_slot >= lc_act) begin
                    n_state = mrit_pkg::ST_DRAIN;
                end
            end
            mrit_pkg::ST_DRAIN: begin
                // Last read data folds into the scanner this cycle
                n_state = mrit_pkg::ST_EMIT;
            end
            mrit_pkg::ST_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = mrit_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mrit_pkg::ST_IDLE;
            end
        endcase
        // A register write drops a partly filled row
        if (i_cfg_valid) begin
            n_fill = '0;
        end
    end

    // Output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mrit_pkg::ST_IDLE;
            r_list_count <= mrit_pkg::LIST_COUNT_RESET;
            r_fill       <= '0;
            r_committed  <= '0;
            r_beat       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_committed <= n_committed;
            r_beat      <= n_beat;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_list_count <= i_cfg_list_count;
            end
        end
    end

    // Item payload held across the scan
    always_ff @(posedge i_clk) begin
        r_row         <= n_row;
        r_nth         <= n_nth;
        r_rd_slot     <= n_rd_slot;
        r_beat_slot   <= n_beat_slot;
        r_pend_status <= n_pend_status;
        r_pend_scan   <= n_pend_scan;
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status    <= r_pend_status;
            r_out_row_count <= mrit_pkg::ROWCNT_W'(r_committed);
            if (r_pend_scan) begin
                r_out_count <= scan_res.count;
                r_out_mask  <= scan_res.mask;
                r_out_found <= scan_res.found;
                r_out_slot  <= scan_res.slot;
                r_out_index <= mrit_pkg::VALUE_W'(scan_index);
            end else begin
                r_out_count <= '0;
                r_out_mask  <= '0;
                r_out_found <= 1'b0;
                r_out_slot  <= '0;
                r_out_index <= '0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_row_count    = r_out_row_count;
    assign o_valid_count  = r_out_count;
    assign o_valid_mask   = r_out_mask;
    assign o_found        = r_out_found;
    assign o_list_slot    = r_out_slot;
    assign o_single_index = r_out_index;

    mrit_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mrit_scan #(
        .INDEX_BITS (INDEX_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_entry (rd_data),
        .o_res   (scan_res),
        .o_index (scan_index)
    );

`ifndef NO_ASSERTIONS
    // Fill slot stays inside the active row width
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lc_act != '0) |-> (LC_W'(r_fill) < lc_act))
        else $error("fill slot beyond list count");

    // Row count never passes the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_committed <= CNT_W'(MAX_ROWS))
        else $error("row count beyond table size");

    // Read data folds into the scanner only during a scan
    a_beat_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat |-> (r_state == mrit_pkg::ST_SCAN || r_state == mrit_pkg::ST_DRAIN))
        else $error("read beat outside scan");

    // A write never overlaps a scan of the same memory
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == mrit_pkg::ST_IDLE && !rd_en))
        else $error("memory write during scan");

    // The committed row count only ever changes by advancing by one
    a_commit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_committed != $past(r_committed)) |->
            (r_committed == $past(r_committed) + CNT_W'(1)))
        else $error("row count jumped");
`endif

endmodule

### design/mrit_store.sv
// Entry memory: one write port, one read port with registered read data.
module mrit_store #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 25
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry into the registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/mrit_scan.sv
// Row scanner: counts valid entries of a row and picks the nth valid one.
module mrit_scan #(
    parameter int INDEX_BITS = mrit_pkg::INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mrit_pkg::t_scan_ctl   i_ctl,
    input  logic [INDEX_BITS:0]   i_entry,
    output mrit_pkg::t_scan_res   o_res,
    output logic [INDEX_BITS-1:0] o_index
);

    mrit_pkg::t_scan_res   r_res;
    mrit_pkg::t_scan_res   n_res;
    logic [INDEX_BITS-1:0] r_index;
    logic [INDEX_BITS-1:0] n_index;

    // Fold one read beat into the running summary
    always_comb begin
        n_res   = r_res;
        n_index = r_index;
        if (i_ctl.clear) begin
            n_res   = '0;
            n_index = '0;
        end else if (i_ctl.beat && i_entry[INDEX_BITS]) begin
            if (!r_res.found &&
                (r_res.count == mrit_pkg::COUNT_W'(i_ctl.nth))) begin
                n_res.found = 1'b1;
                n_res.slot  = i_ctl.slot;
                n_index     = i_entry[INDEX_BITS-1:0];
            end
            n_res.count = r_res.count + mrit_pkg::COUNT_W'(1);
            n_res.mask  = r_res.mask | (mrit_pkg::MASK_W'(1) << i_ctl.slot);
        end
    end

    // Hold the summary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res   <= '0;
            r_index <= '0;
        end else begin
            r_res   <= n_res;
            r_index <= n_index;
        end
    end

    assign o_res   = r_res;
    assign o_index = r_index;

endmodule
